// File: design/sflw_pkg.sv
`default_nettype none

package sflw_pkg;

	localparam int unsigned BUF_DEPTH_DEF = 32;
	localparam int unsigned MAX_CHARS_DEF = 16;

	// Wide enough for every read position the display sequence can reach.
	localparam int unsigned RD_IDX_W = 9;

	localparam logic [7:0] MARK_START = 8'hF5;
	localparam logic [7:0] MARK_END   = 8'hFA;
	localparam logic [7:0] CMD_ROW0   = 8'h80;
	localparam logic [7:0] ROW_OFFSET = 8'h40;
	localparam logic [7:0] ROW0_FLAG  = 8'h01;

	localparam logic [7:0] ENTRY_ROW   = 8'd0;
	localparam logic [7:0] ENTRY_COL   = 8'd1;
	localparam logic [7:0] ENTRY_COUNT = 8'd2;
	localparam logic [7:0] DATA_START  = 8'd3;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_CMD  = 2'd1,
		KIND_DATA = 2'd2
	} kind_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_GT  = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_ECHO,
		S_SH0,
		S_SH1,
		S_SH2,
		S_SH3,
		S_CMD,
		S_DATA
	} state_t;

endpackage

`default_nettype wire

// File: design/sflw_rx_if.sv
`default_nettype none

interface sflw_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: design/sflw_res_if.sv
`default_nettype none

interface sflw_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] value;
	logic       last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

// File: design/sflw_ram.sv
`default_nettype none

module sflw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/sflw_alu.sv
`default_nettype none

module sflw_alu
	import sflw_pkg::*;
(
	input  wire alu_op_t    op,
	input  wire logic [7:0] a,
	input  wire logic [7:0] b,
	output logic      [7:0] sum,
	output logic            gt
);

	always_comb begin
		sum = 8'd0;
		gt  = 1'b0;
		unique case (op)
			ALU_ADD: sum = a + b;
			ALU_GT:  gt  = a > b;
		endcase
	end

endmodule

`default_nettype wire

// File: design/serial_frame_to_lcd_writer.sv
// Serial frame to character-LCD writer.
// The rx channel takes one received serial byte per word. The res channel
// gives words of three fields: kind (echo, LCD command, LCD data), value and
// last, which marks the final word caused by one received byte.
// A start marker opens a frame; frame bytes are stored and echoed until full.
// An end marker reads the first three stored entries, sends one set-address
// command and then up to MAX_CHARS data words from entry three onwards.
// Timing: a byte is taken in one cycle and decoded in the next. An echo is
// loaded into the output register in S_ECHO, which follows S_DEC and waits
// while the output register is stalled. An end marker reads the header in
// S_SH0 to S_SH3 via the buffer's single registered read port, then one
// word per cycle unless stalled, the read address running one entry ahead.
// rx.ready is high only when the sequencer is idle. If the receiver holds
// res.ready low, the output register holds its word and the sequencer waits.
// Reset clears the frame flag, the write index, the output valid flag and the
// per-entry valid bits, so every buffer entry reads as zero until written.
`default_nettype none

module serial_frame_to_lcd_writer
	import sflw_pkg::*;
#(
	parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF,
	parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sflw_rx_if.sink     rx,
	sflw_res_if.source  res
);

	localparam int unsigned AW = $clog2(BUF_DEPTH);
	localparam int unsigned WW = $clog2(BUF_DEPTH + 1);

	state_t state_q, state_d;

	logic [7:0]          byte_q;
	logic                in_frame_q;
	logic [WW-1:0]       wi_q;
	logic [BUF_DEPTH-1:0] valid_q;
	logic [7:0]          base_q;
	logic [7:0]          cmd_q;
	logic [7:0]          count_q;
	logic [7:0]          idx_q;
	logic                rd_ok_q;

	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [7:0]          out_value_q;
	logic                out_last_q;

	logic                emit_ok;
	logic                full;
	logic [7:0]          rd_eff;
	logic [7:0]          ram_rdata;

	// Outputs of the control decode.
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [7:0]          ram_wdata;
	logic [RD_IDX_W-1:0] rd_idx;
	alu_op_t             alu_op;
	logic [7:0]          alu_a;
	logic [7:0]          alu_b;
	logic [7:0]          alu_sum;
	logic                alu_gt;
	logic                emit;
	kind_t               emit_kind;
	logic [7:0]          emit_value;
	logic                emit_last;

	assign emit_ok  = !out_valid_q || res.ready;
	assign full     = wi_q == WW'(BUF_DEPTH);
	assign rd_eff   = rd_ok_q ? ram_rdata : 8'd0;
	assign rx.ready = state_q == S_IDLE;

	sflw_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	sflw_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum),
		.gt  (alu_gt)
	);

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = wi_q[AW-1:0];
		ram_wdata  = byte_q;
		rd_idx     = RD_IDX_W'(DATA_START) + RD_IDX_W'(idx_q);
		alu_op     = ALU_ADD;
		alu_a      = idx_q;
		alu_b      = 8'd1;
		emit       = 1'b0;
		emit_kind  = KIND_ECHO;
		emit_value = byte_q;
		emit_last  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
			end
			S_DEC: begin
				ram_we = (byte_q != MARK_END) && in_frame_q && !full;
			end
			S_ECHO: begin
				emit = 1'b1;
			end
			S_SH0: begin
				rd_idx = RD_IDX_W'(ENTRY_ROW);
			end
			S_SH1: begin
				rd_idx = RD_IDX_W'(ENTRY_COL);
			end
			S_SH2: begin
				rd_idx = RD_IDX_W'(ENTRY_COUNT);
				alu_a  = base_q;
				alu_b  = rd_eff;
			end
			S_SH3: begin
				alu_op    = ALU_GT;
				alu_a     = rd_eff;
				alu_b     = 8'(MAX_CHARS);
				ram_we    = alu_gt;
				ram_waddr = AW'(ENTRY_COUNT);
				ram_wdata = 8'(MAX_CHARS);
			end
			S_CMD: begin
				emit       = 1'b1;
				emit_kind  = KIND_CMD;
				emit_value = cmd_q;
				emit_last  = count_q == 8'd0;
			end
			S_DATA: begin
				emit       = 1'b1;
				emit_kind  = KIND_DATA;
				emit_value = rd_eff;
				emit_last  = alu_sum == count_q;
				// Read ahead one entry so a word leaves each cycle unless stalled.
				if (emit_ok) begin
					rd_idx = RD_IDX_W'(DATA_START) + RD_IDX_W'(alu_sum);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (rx.valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				priority if (byte_q == MARK_END) begin
					state_d = S_SH0;
				end else if (in_frame_q && !full) begin
					state_d = S_ECHO;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ECHO: begin
				if (emit_ok) begin
					state_d = S_IDLE;
				end
			end
			S_SH0: state_d = S_SH1;
			S_SH1: state_d = S_SH2;
			S_SH2: state_d = S_SH3;
			S_SH3: state_d = S_CMD;
			S_CMD: begin
				if (emit_ok) begin
					state_d = emit_last ? S_IDLE : S_DATA;
				end
			end
			S_DATA: begin
				if (emit_ok && emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_frame_q  <= 1'b0;
			wi_q        <= '0;
			valid_q     <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_ok_q <= (rd_idx < RD_IDX_W'(BUF_DEPTH)) && valid_q[rd_idx[AW-1:0]];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (emit && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_DEC) begin
				priority if (byte_q == MARK_END) begin
					in_frame_q <= 1'b0;
				end else if (byte_q == MARK_START) begin
					// A start marker inside a frame is stored first, then restarts it.
					in_frame_q <= 1'b1;
					wi_q       <= '0;
				end else if (in_frame_q && !full) begin
					wi_q <= wi_q + WW'(1);
				end
			end
			if (state_q == S_SH0) begin
				wi_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_q <= rx.rx_byte;
		end
		if (emit && emit_ok) begin
			out_kind_q  <= emit_kind;
			out_value_q <= emit_value;
			out_last_q  <= emit_last;
		end
		unique case (state_q)
			S_SH1: base_q <= (rd_eff == ROW0_FLAG) ? CMD_ROW0 : CMD_ROW0 + ROW_OFFSET;
			S_SH2: cmd_q <= alu_sum;
			S_SH3: begin
				count_q <= alu_gt ? 8'(MAX_CHARS) : rd_eff;
				idx_q   <= 8'd0;
			end
			S_DATA: begin
				if (emit_ok) begin
					idx_q <= alu_sum;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid = out_valid_q;
	assign res.kind  = out_kind_q;
	assign res.value = out_value_q;
	assign res.last  = out_last_q;

endmodule

`default_nettype wire

// File: design/sflw_checker.sv
`default_nettype none

module sflw_checker
	import sflw_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_valid,
	input wire logic       rx_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] value,
	input wire logic       last
);

	// A word that is not taken stays as it is.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value) && $stable(kind)
			&& $stable(last))
		else $error("result word changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> kind == KIND_ECHO || kind == KIND_CMD || kind == KIND_DATA)
		else $error("result word carries an unused kind");

	// An echo is always the only word caused by its byte.
	a_echo_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_ECHO |-> last)
		else $error("echo word without last");

	// The sequencer is busy in the cycle after it takes a byte.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready |=> !rx_ready)
		else $error("byte taken in the cycle after an accepted byte");

endmodule

bind serial_frame_to_lcd_writer sflw_checker u_sflw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx.valid),
	.rx_ready  (rx.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.kind      (res.kind),
	.value     (res.value),
	.last      (res.last)
);

`default_nettype wire
